FILE: design/nrca_pkg.sv
package nrca_pkg;

    localparam int REGION_COUNT = 64;
    localparam int STACK_DEPTH  = 16;

    // Stack level runs from zero to STACK_DEPTH inclusive.
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int TOP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef logic [5:0]         region_t;
    typedef logic [63:0]        cycles_t;
    typedef logic [31:0]        hits_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [TOP_W-1:0]   top_t;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_BEGIN = 3'd2,
        CMD_END   = 3'd3,
        CMD_READ  = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADREG = 2'd3
    } status_e;

    typedef struct packed {
        logic [2:0] cmd;
        region_t    region;
        cycles_t    timestamp;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        hits_t      hits;
        cycles_t    inclusive_cycles;
        cycles_t    exclusive_cycles;
        cycles_t    total_cycles;
    } out_t;

endpackage

FILE: design/nested_region_cycle_accounting_core.sv
// Channel   Ports                     Beat taken when
// --------  ------------------------  ------------------------------
// command   start, busy, item         rising edge with start high, busy low
// result    done, result              rising edge ending the cycle done is high
//
// A command beat is taken at a rising edge, where the tables are read; the item is
// worked in the next cycle, and the result is registered from it, shown for one cycle.
// Most commands hold busy only through the work cycle after the beat; a block end
// that pops a region opened under a different parent also holds it through the
// parent write state, since the exclusive-count table has one write port and both
// the region and its parent are written.
// Reset clears all counters at once through per-entry valid bits; no sweep is needed.
// The receiver cannot stall; results are never held back.
module nested_region_cycle_accounting_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  nrca_pkg::in_t   item,
    output logic            done,
    output nrca_pkg::out_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WRP
    } state_t;

    state_t              state_reg, state_next;
    nrca_pkg::in_t       in_reg;
    logic                done_reg;
    nrca_pkg::out_t      result_reg, result_next;

    // Region tables, one row per region.
    nrca_pkg::hits_t     hits_mem [nrca_pkg::REGION_COUNT];
    nrca_pkg::cycles_t   incl_mem [nrca_pkg::REGION_COUNT];
    nrca_pkg::cycles_t   excl_mem [nrca_pkg::REGION_COUNT];
    logic [nrca_pkg::REGION_COUNT-1:0] hv_reg, ev_reg;

    nrca_pkg::hits_t     hits_rd_reg;
    nrca_pkg::cycles_t   incl_rd_reg, exa_rd_reg, exb_rd_reg;
    logic                hva_reg, eva_reg, evb_reg;

    // Open-block stack.
    nrca_pkg::region_t   open_region_reg    [nrca_pkg::STACK_DEPTH];
    nrca_pkg::cycles_t   open_time_reg      [nrca_pkg::STACK_DEPTH];
    nrca_pkg::cycles_t   open_old_incl_reg  [nrca_pkg::STACK_DEPTH];
    nrca_pkg::region_t   open_parent_reg    [nrca_pkg::STACK_DEPTH];
    nrca_pkg::level_t    level_reg, level_next;
    nrca_pkg::region_t   parent_reg, parent_next;
    nrca_pkg::cycles_t   sess_start_reg, sess_start_next;
    nrca_pkg::cycles_t   sess_stop_reg, sess_stop_next;

    // Parent exclusive update held over for the second write cycle.
    nrca_pkg::region_t   wrp_addr_reg;
    nrca_pkg::cycles_t   wrp_data_reg;

    logic                accept;
    nrca_pkg::top_t      top_idx, push_idx;
    nrca_pkg::region_t   top_region, top_parent, addr_a;
    nrca_pkg::cycles_t   top_time, top_old_incl;

    nrca_pkg::hits_t     hits_old;
    nrca_pkg::cycles_t   incl_old, exa_old, exb_old, delta;
    logic                same_region;

    logic                push_en, pop_en, tbl_we, excl_we;
    nrca_pkg::region_t   excl_waddr;
    nrca_pkg::cycles_t   excl_wdata, excl_r_new, excl_p_new;
    nrca_pkg::hits_t     hits_new;
    nrca_pkg::cycles_t   incl_new;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign top_idx      = nrca_pkg::TOP_W'(level_reg - nrca_pkg::level_t'(1));
    assign push_idx     = level_reg[nrca_pkg::TOP_W-1:0];
    assign top_region   = open_region_reg[top_idx];
    assign top_parent   = open_parent_reg[top_idx];
    assign top_time     = open_time_reg[top_idx];
    assign top_old_incl = open_old_incl_reg[top_idx];

    // A block end works on the region at the top of the stack.
    assign addr_a = (item.cmd == nrca_pkg::CMD_END) ? top_region : item.region;

    // Entries never written since reset read as zero.
    assign hits_old = hva_reg ? hits_rd_reg : '0;
    assign incl_old = hva_reg ? incl_rd_reg : '0;
    assign exa_old  = eva_reg ? exa_rd_reg  : '0;
    assign exb_old  = evb_reg ? exb_rd_reg  : '0;

    assign delta       = in_reg.timestamp - top_time;
    assign same_region = (top_region == top_parent);
    assign hits_new    = hits_old + nrca_pkg::hits_t'(1);
    assign incl_new    = top_old_incl + delta;
    // A region nested in itself gets plus and minus delta: no net change.
    assign excl_r_new  = same_region ? exa_old : exa_old + delta;
    assign excl_p_new  = exb_old - delta;

    always_comb
    begin
        state_next      = state_reg;
        result_next     = result_reg;
        level_next      = level_reg;
        parent_next     = parent_reg;
        sess_start_next = sess_start_reg;
        sess_stop_next  = sess_stop_reg;
        push_en         = 1'b0;
        pop_en          = 1'b0;
        tbl_we          = 1'b0;
        excl_we         = 1'b0;
        excl_waddr      = top_region;
        excl_wdata      = excl_r_new;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next                   = S_IDLE;
                result_next.status           = nrca_pkg::ST_OK;
                result_next.hits             = '0;
                result_next.inclusive_cycles = '0;
                result_next.exclusive_cycles = '0;
                case (in_reg.cmd)
                    nrca_pkg::CMD_START:
                    begin
                        sess_start_next = in_reg.timestamp;
                    end
                    nrca_pkg::CMD_STOP:
                    begin
                        sess_stop_next = in_reg.timestamp;
                    end
                    nrca_pkg::CMD_BEGIN:
                    begin
                        priority if (in_reg.region == '0 ||
                                     int'(in_reg.region) >= nrca_pkg::REGION_COUNT)
                        begin
                            result_next.status = nrca_pkg::ST_BADREG;
                        end
                        else if (level_reg >= nrca_pkg::level_t'(nrca_pkg::STACK_DEPTH))
                        begin
                            result_next.status = nrca_pkg::ST_FULL;
                        end
                        else
                        begin
                            push_en     = 1'b1;
                            level_next  = level_reg + nrca_pkg::level_t'(1);
                            parent_next = in_reg.region;
                        end
                    end
                    nrca_pkg::CMD_END:
                    begin
                        if (level_reg == '0)
                        begin
                            result_next.status = nrca_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            pop_en      = 1'b1;
                            tbl_we      = 1'b1;
                            excl_we     = 1'b1;
                            level_next  = level_reg - nrca_pkg::level_t'(1);
                            parent_next = top_parent;
                            result_next.hits             = hits_new;
                            result_next.inclusive_cycles = incl_new;
                            result_next.exclusive_cycles = excl_r_new;
                            if (!same_region)
                            begin
                                state_next = S_WRP;
                            end
                        end
                    end
                    nrca_pkg::CMD_READ:
                    begin
                        if (int'(in_reg.region) >= nrca_pkg::REGION_COUNT)
                        begin
                            result_next.status = nrca_pkg::ST_BADREG;
                        end
                        else
                        begin
                            result_next.hits             = hits_old;
                            result_next.inclusive_cycles = incl_old;
                            result_next.exclusive_cycles = exa_old;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                result_next.total_cycles = sess_stop_next - sess_start_next;
            end
            S_WRP:
            begin
                state_next = S_IDLE;
                excl_we    = 1'b1;
                excl_waddr = wrp_addr_reg;
                excl_wdata = wrp_data_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= (state_reg == S_EXEC);
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            parent_reg     <= '0;
            sess_start_reg <= '0;
            sess_stop_reg  <= '0;
            hv_reg         <= '0;
            ev_reg         <= '0;
        end
        else
        begin
            level_reg      <= level_next;
            parent_reg     <= parent_next;
            sess_start_reg <= sess_start_next;
            sess_stop_reg  <= sess_stop_next;
            if (tbl_we)
            begin
                hv_reg[top_region] <= 1'b1;
            end
            if (excl_we)
            begin
                ev_reg[excl_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg      <= item;
            hits_rd_reg <= hits_mem[addr_a];
            incl_rd_reg <= incl_mem[addr_a];
            exa_rd_reg  <= excl_mem[addr_a];
            exb_rd_reg  <= excl_mem[top_parent];
            hva_reg     <= hv_reg[addr_a];
            eva_reg     <= ev_reg[addr_a];
            evb_reg     <= ev_reg[top_parent];
        end
        if (tbl_we)
        begin
            hits_mem[top_region] <= hits_new;
            incl_mem[top_region] <= incl_new;
        end
        if (excl_we)
        begin
            excl_mem[excl_waddr] <= excl_wdata;
        end
        if (pop_en)
        begin
            wrp_addr_reg <= top_parent;
            wrp_data_reg <= excl_p_new;
        end
        if (push_en)
        begin
            open_region_reg[push_idx]   <= in_reg.region;
            open_time_reg[push_idx]     <= in_reg.timestamp;
            open_old_incl_reg[push_idx] <= incl_old;
            open_parent_reg[push_idx]   <= parent_reg;
        end
    end

`ifndef SYNTHESIS
    // Every accepted command yields exactly one result, done being registered from its work cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted command produced no result");

    // A result only comes out of the work cycle.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without a work cycle");

    // The second write cycle only follows a block end that popped the stack.
    a_wrp_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRP) |-> $past(pop_en) &&
            (level_reg == $past(level_reg) - nrca_pkg::level_t'(1)))
        else $error("parent write cycle without a pop");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= nrca_pkg::level_t'(nrca_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");
`endif

endmodule

FILE: verif/nested_region_cycle_accounting_core_tb.sv
module nested_region_cycle_accounting_core_tb;
    import nrca_pkg::*;

    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
    localparam cycles_t    TS_MAX           = '1;
    localparam int         ITEM_TARGET      = 740;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam int         DRAIN_CYCLES     = 8;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    in_t     item  = '0;
    logic    busy;
    logic    done;
    out_t    result;

    nested_region_cycle_accounting_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Profiler state as the testbench expects it to be.
    hits_t   tally_hits    [REGION_COUNT];
    cycles_t tally_incl    [REGION_COUNT];
    cycles_t tally_excl    [REGION_COUNT];
    region_t nest_region   [STACK_DEPTH];
    cycles_t nest_t0       [STACK_DEPTH];
    cycles_t nest_old_incl [STACK_DEPTH];
    region_t nest_parent   [STACK_DEPTH];
    int      nest_level;
    region_t owner;
    cycles_t sess_start;
    cycles_t sess_stop;

    out_t    pending_reports [$];
    int      items_sent      = 0;
    int      reports_checked = 0;
    int      mismatches      = 0;
    int      cycle_count     = 0;
    int      burst_left      = 0;
    int      status_seen     [4];
    cycles_t now_ts          = '0;

    function automatic void clear_profile_state();
        for (int i = 0; i < REGION_COUNT; i++)
        begin
            tally_hits[i] = '0;
            tally_incl[i] = '0;
            tally_excl[i] = '0;
        end
        nest_level = 0;
        owner      = '0;
        sess_start = '0;
        sess_stop  = '0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
    endfunction

    // Applies one command to the expected state and returns the report it should give.
    function automatic out_t account_command(in_t c);
        out_t    rep;
        bit      show;
        region_t idx;
        region_t r;
        region_t p;
        int      top;
        cycles_t delta;
        rep        = '0;
        show       = 1'b0;
        idx        = '0;
        rep.status = ST_OK;
        case (c.cmd)
            CMD_START: sess_start = c.timestamp;
            CMD_STOP:  sess_stop  = c.timestamp;
            CMD_BEGIN:
            begin
                if (c.region == '0 || int'(c.region) >= REGION_COUNT)
                    rep.status = ST_BADREG;
                else if (nest_level >= STACK_DEPTH)
                    rep.status = ST_FULL;
                else
                begin
                    nest_region[nest_level]   = c.region;
                    nest_t0[nest_level]       = c.timestamp;
                    nest_old_incl[nest_level] = tally_incl[c.region];
                    nest_parent[nest_level]   = owner;
                    nest_level++;
                    owner = c.region;
                end
            end
            CMD_END:
            begin
                if (nest_level == 0 || nest_level > STACK_DEPTH)
                    rep.status = ST_EMPTY;
                else
                begin
                    top   = nest_level - 1;
                    r     = nest_region[top];
                    p     = nest_parent[top];
                    delta = c.timestamp - nest_t0[top];
                    // A region nested in itself is its own parent, so the two
                    // exclusive updates cancel.
                    tally_hits[r] = tally_hits[r] + 1;
                    tally_incl[r] = nest_old_incl[top] + delta;
                    tally_excl[r] = tally_excl[r] + delta;
                    tally_excl[p] = tally_excl[p] - delta;
                    owner         = p;
                    nest_level    = top;
                    show          = 1'b1;
                    idx           = r;
                end
            end
            CMD_READ:
            begin
                if (int'(c.region) >= REGION_COUNT)
                    rep.status = ST_BADREG;
                else
                begin
                    show = 1'b1;
                    idx  = c.region;
                end
            end
            default: ;
        endcase
        if (show)
        begin
            rep.hits             = tally_hits[idx];
            rep.inclusive_cycles = tally_incl[idx];
            rep.exclusive_cycles = tally_excl[idx];
        end
        rep.total_cycles = sess_stop - sess_start;
        return rep;
    endfunction

    // Sends one command beat; the sender runs in bursts with short gaps between.
    task automatic send_item(input logic [2:0] op, input region_t r, input cycles_t ts);
        in_t beat;
        int  gap;
        beat.cmd       = op;
        beat.region    = r;
        beat.timestamp = ts;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        start <= 1'b1;
        item  <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_reports.push_back(account_command(beat));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected report, expected none, got %0h", $time, result);
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("status", 64'(want.status), 64'(result.status));
                compare_field("hits", 64'(want.hits), 64'(result.hits));
                compare_field("inclusive_cycles", want.inclusive_cycles,
                              result.inclusive_cycles);
                compare_field("exclusive_cycles", want.exclusive_cycles,
                              result.exclusive_cycles);
                compare_field("total_cycles", want.total_cycles, result.total_cycles);
                status_seen[want.status]++;
                reports_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic cycles_t next_stamp();
        if ($urandom_range(0, 29) == 0)
            now_ts = {$urandom, $urandom};
        else
            now_ts = now_ts + $urandom_range(0, 40);
        return now_ts;
    endfunction

    function automatic region_t pick_region();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return '0;
        if (k < 4)
            return owner;
        return region_t'($urandom_range(1, REGION_COUNT - 1));
    endfunction

    function automatic region_t any_region();
        return region_t'($urandom_range(0, REGION_COUNT - 1));
    endfunction

    task automatic test_sessions();
        send_item(CMD_READ, region_t'(0), '0);
        send_item(CMD_READ, region_t'(REGION_COUNT - 1), TS_MAX);
        send_item(CMD_START, any_region(), TS_MAX);
        send_item(CMD_STOP, any_region(), '0);
        send_item(CMD_START, any_region(), '0);
        send_item(CMD_STOP, any_region(), TS_MAX);
    endtask

    task automatic test_error_cases();
        send_item(CMD_BEGIN, region_t'(0), 64'd50);
        send_item(CMD_END, any_region(), 64'd60);
        send_item(CMD_READ, region_t'(0), 64'd70);
    endtask

    task automatic test_nesting();
        send_item(CMD_BEGIN, region_t'(5), 64'd100);
        // The same region opened inside itself.
        send_item(CMD_BEGIN, region_t'(5), 64'd110);
        send_item(CMD_END, any_region(), 64'd150);
        send_item(CMD_END, any_region(), 64'd200);
        send_item(CMD_READ, region_t'(5), 64'd210);
        send_item(CMD_READ, region_t'(0), 64'd220);
        // Blocks near the top of the timestamp range; the outer one's delta wraps past it.
        send_item(CMD_BEGIN, region_t'(REGION_COUNT - 1), TS_MAX - 64'd15);
        send_item(CMD_BEGIN, region_t'(1), TS_MAX - 64'd5);
        send_item(CMD_END, any_region(), TS_MAX);
        send_item(CMD_END, any_region(), 64'd16);
        send_item(CMD_READ, region_t'(REGION_COUNT - 1), 64'd20);
    endtask

    task automatic test_unused_commands();
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
            send_item(3'(c), any_region(), {$urandom, $urandom});
    endtask

    // One profiling session: a start, a climb of nested regions, then a random walk of
    // opens, ends and reads back down to the root, and a stop.
    task automatic run_profile_session();
        int depth_goal;
        int choice;
        depth_goal = ($urandom_range(0, 7) == 0) ? STACK_DEPTH + $urandom_range(1, 2)
                                                 : $urandom_range(1, 5);
        if ($urandom_range(0, 5) == 0)
            now_ts = TS_MAX - $urandom_range(0, 200);
        send_item(CMD_START, any_region(), next_stamp());
        repeat (depth_goal)
            send_item(CMD_BEGIN, pick_region(), next_stamp());
        while (nest_level > 0)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 3 && nest_level < depth_goal)
                send_item(CMD_BEGIN, pick_region(), next_stamp());
            else if (choice < 5)
                send_item(CMD_READ, any_region(), next_stamp());
            else
                send_item(CMD_END, any_region(), next_stamp());
        end
        if ($urandom_range(0, 3) == 0)
            send_item(CMD_END, any_region(), next_stamp());
        send_item(CMD_STOP, any_region(), next_stamp());
        if ($urandom_range(0, 1) == 0)
            send_item(CMD_READ, region_t'(0), next_stamp());
    endtask

    task automatic run_noise_burst();
        int n;
        n = $urandom_range(3, 10);
        repeat (n)
            send_item(3'($urandom_range(0, 7)), any_region(), {$urandom, $urandom});
    endtask

    task automatic test_random_traffic();
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
                run_noise_burst();
            else
                run_profile_session();
        end
    endtask

    initial
    begin
        clear_profile_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_sessions();
        test_error_cases();
        test_nesting();
        test_unused_commands();
        test_random_traffic();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d commands and checked %0d reports in %0d cycles.",
                 items_sent, reports_checked, cycle_count);
        $display("Reports seen: stack full %0d, stack empty %0d, bad region %0d.",
                 status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_BADREG]);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
design/nrca_pkg.sv
design/nested_region_cycle_accounting_core.sv
verif/nested_region_cycle_accounting_core_tb.sv
